// File: rtl/stabilizer_tableau_gate_engine_core_defines.svh
// Assertion macros shared by the tableau gate engine RTL.
`ifndef STABILIZER_TABLEAU_GATE_ENGINE_CORE_DEFINES_SVH
`define STABILIZER_TABLEAU_GATE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STGE_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define STGE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/stge_pkg.sv
// Types, constants and gate tables of the tableau gate engine.
package stge_pkg;

   localparam int QUBITS           = 64;
   localparam int WORDS_PER_COLUMN = 2;
   localparam int WORD_BITS        = 64;

   localparam int DEPTH  = QUBITS * WORDS_PER_COLUMN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WIDX_W = (WORDS_PER_COLUMN > 1) ? $clog2(WORDS_PER_COLUMN) : 1;
   localparam int CNT_W  = $clog2(WORDS_PER_COLUMN + 1);

   localparam logic [4:0] GATE_COUNT = 5'd24;
   localparam logic [4:0] MODE_CNOT  = 5'd24;
   localparam logic [4:0] MODE_CZ    = 5'd25;
   localparam logic [4:0] MODE_WRITE = 5'd26;
   localparam logic [4:0] MODE_READ  = 5'd27;

   localparam logic [1:0] KIND_X     = 2'd0;
   localparam logic [1:0] KIND_Z     = 2'd1;
   localparam logic [1:0] KIND_PHASE = 2'd2;

   localparam logic [2:0] PF_NONE  = 3'd0;
   localparam logic [2:0] PF_XZ    = 3'd1;
   localparam logic [2:0] PF_X     = 3'd2;
   localparam logic [2:0] PF_XNZ   = 3'd3;
   localparam logic [2:0] PF_Z     = 3'd4;
   localparam logic [2:0] PF_XOR   = 3'd5;
   localparam logic [2:0] PF_NXZ   = 3'd6;
   localparam logic [2:0] PF_OR    = 3'd7;

   localparam logic [1:0] MIX_NONE = 2'd0;
   localparam logic [1:0] MIX_ZX   = 2'd1;
   localparam logic [1:0] MIX_XZ   = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [4:0]  mode;
      logic [5:0]  target_qubit;
      logic [5:0]  control_qubit;
      logic [1:0]  word_kind;
      logic        word_index;
      logic [63:0] word_data;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        done_res;
   } rsp_type;

   typedef struct packed {
      logic [2:0] phase_fn;
      logic [1:0] mix;
      logic       exch;
   } gate_desc_type;

   function automatic gate_desc_type gate_desc(input logic [4:0] m);
      gate_desc_type d;
      unique case (m)
         5'd0:    d = '{PF_XZ,   MIX_NONE, 1'b1};
         5'd1:    d = '{PF_XZ,   MIX_ZX,   1'b0};
         5'd2:    d = '{PF_X,    MIX_NONE, 1'b0};
         5'd3:    d = '{PF_XNZ,  MIX_ZX,   1'b0};
         5'd4:    d = '{PF_NONE, MIX_NONE, 1'b0};
         5'd5:    d = '{PF_Z,    MIX_NONE, 1'b0};
         5'd6:    d = '{PF_XOR,  MIX_NONE, 1'b0};
         5'd7:    d = '{PF_NXZ,  MIX_NONE, 1'b1};
         5'd8:    d = '{PF_NXZ,  MIX_ZX,   1'b0};
         5'd9:    d = '{PF_OR,   MIX_ZX,   1'b0};
         5'd10:   d = '{PF_XNZ,  MIX_NONE, 1'b1};
         5'd11:   d = '{PF_XOR,  MIX_NONE, 1'b1};
         5'd12:   d = '{PF_NONE, MIX_XZ,   1'b1};
         5'd13:   d = '{PF_Z,    MIX_XZ,   1'b1};
         5'd14:   d = '{PF_NONE, MIX_XZ,   1'b1};
         5'd15:   d = '{PF_NONE, MIX_ZX,   1'b1};
         5'd16:   d = '{PF_XOR,  MIX_ZX,   1'b1};
         5'd17:   d = '{PF_Z,    MIX_ZX,   1'b1};
         5'd18:   d = '{PF_XOR,  MIX_XZ,   1'b1};
         5'd19:   d = '{PF_X,    MIX_XZ,   1'b1};
         5'd20:   d = '{PF_NXZ,  MIX_XZ,   1'b0};
         5'd21:   d = '{PF_XZ,   MIX_XZ,   1'b0};
         5'd22:   d = '{PF_OR,   MIX_XZ,   1'b0};
         5'd23:   d = '{PF_XNZ,  MIX_XZ,   1'b0};
         default: d = '{PF_NONE, MIX_NONE, 1'b0};
      endcase
      return d;
   endfunction

   function automatic word_type phase_term(input logic [2:0] f, input word_type x,
                                           input word_type z);
      word_type r;
      unique case (f)
         PF_XZ:   r = x & z;
         PF_X:    r = x;
         PF_XNZ:  r = x & ~z;
         PF_Z:    r = z;
         PF_XOR:  r = x ^ z;
         PF_NXZ:  r = ~x & z;
         PF_OR:   r = x | z;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] word_addr(input logic [5:0] q, input int w);
      return ADDR_W'(int'(q) * WORDS_PER_COLUMN + w);
   endfunction

endpackage

// File: rtl/stge_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/stabilizer_tableau_gate_engine_core.sv
// Tableau gate engine: X and Z column RAMs, phase words and the gate sequencer.
// A gate is accepted, then each word goes through S_RA, S_RB and S_WR (and S_WR2 for CZ)
// before S_DONE posts the result; column-exchanging gates sweep every word, the others
// the active words. Word items pass through S_WORD, X and Z reads also through S_RD.
// Synchronous reset clears the per-entry valid bits, the phase words and active_words
// (to 2) at once, so the tableau reads as all zero; no sweep.
`include "stabilizer_tableau_gate_engine_core_defines.svh"

module stabilizer_tableau_gate_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stge_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stge_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RA   = 3'd1;
   localparam logic [2:0] S_RB   = 3'd2;
   localparam logic [2:0] S_WR   = 3'd3;
   localparam logic [2:0] S_WR2  = 3'd4;
   localparam logic [2:0] S_WORD = 3'd5;
   localparam logic [2:0] S_RD   = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]                   state_ff, state_in;
   stge_pkg::req_type            item_ff, item_in;
   stge_pkg::gate_desc_type      desc_ff, desc_in;
   logic                         two_ff, two_in;
   logic                         cz_ff, cz_in;
   logic [stge_pkg::CNT_W-1:0]   w_ff, w_in;
   logic [stge_pkg::CNT_W-1:0]   limit_ff, limit_in;
   logic [1:0]                   aw_ff;
   logic [stge_pkg::CNT_W-1:0]   live;
   stge_pkg::word_type           phase_ff [stge_pkg::WORDS_PER_COLUMN];
   logic [stge_pkg::DEPTH-1:0]   xval_ff, zval_ff;
   logic                         xv_ff, zv_ff;
   stge_pkg::word_type           xa_ff, za_ff, xb_ff;
   logic [63:0]                  rd_ff, rd_in;
   logic                         rsp_valid_ff;
   stge_pkg::rsp_type            rsp_ff;

   logic [stge_pkg::ADDR_W-1:0]  raddr, addr_a, addr_b, x_waddr, z_waddr;
   logic                         x_we, z_we, ph_we;
   stge_pkg::word_type           x_wdata, z_wdata, ph_wdata, rdx, rdz, xe, ze;
   logic [stge_pkg::WIDX_W-1:0]  ph_idx;
   logic                         load_rsp;

   stge_ram #(.WIDTH(stge_pkg::WORD_BITS), .DEPTH(stge_pkg::DEPTH)) u_xram (
      .clock(clock), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
      .raddr(raddr), .rdata(rdx)
   );

   stge_ram #(.WIDTH(stge_pkg::WORD_BITS), .DEPTH(stge_pkg::DEPTH)) u_zram (
      .clock(clock), .we(z_we), .waddr(z_waddr), .wdata(z_wdata),
      .raddr(raddr), .rdata(rdz)
   );

   // Entries never written read as zero.
   assign xe = xv_ff ? rdx : '0;
   assign ze = zv_ff ? rdz : '0;

   always_comb begin
      if (32'(aw_ff) > stge_pkg::WORDS_PER_COLUMN) begin
         live = stge_pkg::CNT_W'(stge_pkg::WORDS_PER_COLUMN);
      end else begin
         live = stge_pkg::CNT_W'(aw_ff);
      end
   end

   assign addr_a = stge_pkg::word_addr(two_ff ? item_ff.control_qubit : item_ff.target_qubit,
                                       int'(w_ff));
   assign addr_b = stge_pkg::word_addr(item_ff.target_qubit, int'(w_ff));
   assign ph_idx = stge_pkg::WIDX_W'(w_ff);

   always_comb begin
      stge_pkg::word_type xt, zt, xn, zn, term;
      logic               upd;
      xt       = '0;
      zt       = '0;
      xn       = '0;
      zn       = '0;
      term     = '0;
      upd      = 1'b0;
      state_in = state_ff;
      item_in  = item_ff;
      desc_in  = desc_ff;
      two_in   = two_ff;
      cz_in    = cz_ff;
      w_in     = w_ff;
      limit_in = limit_ff;
      rd_in    = rd_ff;
      raddr    = addr_a;
      x_we     = 1'b0;
      z_we     = 1'b0;
      x_waddr  = addr_b;
      z_waddr  = addr_b;
      x_wdata  = '0;
      z_wdata  = '0;
      ph_we    = 1'b0;
      ph_wdata = '0;
      load_rsp = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               desc_in  = stge_pkg::gate_desc(req_data.mode);
               two_in   = 1'b0;
               cz_in    = req_data.mode == stge_pkg::MODE_CZ;
               w_in     = '0;
               rd_in    = '0;
               state_in = S_DONE;
               if (req_data.mode < stge_pkg::GATE_COUNT) begin
                  limit_in = desc_in.exch ? stge_pkg::CNT_W'(stge_pkg::WORDS_PER_COLUMN)
                                          : live;
                  if (32'(req_data.target_qubit) < stge_pkg::QUBITS && limit_in != '0) begin
                     state_in = S_RA;
                  end
               end else if (req_data.mode == stge_pkg::MODE_CNOT ||
                            req_data.mode == stge_pkg::MODE_CZ) begin
                  two_in   = 1'b1;
                  limit_in = live;
                  if (32'(req_data.target_qubit) < stge_pkg::QUBITS &&
                      32'(req_data.control_qubit) < stge_pkg::QUBITS &&
                      req_data.target_qubit != req_data.control_qubit && live != '0) begin
                     state_in = S_RA;
                  end
               end else if (req_data.mode == stge_pkg::MODE_WRITE ||
                            req_data.mode == stge_pkg::MODE_READ) begin
                  state_in = S_WORD;
               end
            end
         end
         S_RA: begin
            raddr    = addr_a;
            state_in = S_RB;
         end
         S_RB: begin
            raddr    = addr_b;
            state_in = S_WR;
         end
         S_WR: begin
            if (!two_ff) begin
               upd  = w_ff < live;
               term = upd ? stge_pkg::phase_term(desc_ff.phase_fn, xa_ff, za_ff) : '0;
               xn   = (upd && desc_ff.mix == stge_pkg::MIX_XZ) ? (xa_ff ^ za_ff) : xa_ff;
               zn   = (upd && desc_ff.mix == stge_pkg::MIX_ZX) ? (za_ff ^ xa_ff) : za_ff;
               x_we    = 1'b1;
               z_we    = 1'b1;
               x_wdata = desc_ff.exch ? zn : xn;
               z_wdata = desc_ff.exch ? xn : zn;
            end else if (cz_ff) begin
               xt      = xe;
               zt      = ze;
               term    = xa_ff & xt & (za_ff ^ zt);
               z_we    = 1'b1;
               z_wdata = zt ^ xa_ff;
            end else begin
               xt      = xe;
               zt      = ze;
               term    = xa_ff & zt & ~(xt ^ za_ff);
               x_we    = 1'b1;
               x_wdata = xt ^ xa_ff;
               z_we    = 1'b1;
               z_waddr = addr_a;
               z_wdata = za_ff ^ zt;
            end
            ph_we    = 1'b1;
            ph_wdata = phase_ff[ph_idx] ^ term;
            if (two_ff && cz_ff) begin
               state_in = S_WR2;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = (w_in == limit_ff) ? S_DONE : S_RA;
            end
         end
         S_WR2: begin
            z_we     = 1'b1;
            z_waddr  = addr_a;
            z_wdata  = za_ff ^ xb_ff;
            w_in     = w_ff + 1'b1;
            state_in = (w_in == limit_ff) ? S_DONE : S_RA;
         end
         S_WORD: begin
            raddr    = stge_pkg::word_addr(item_ff.target_qubit, int'(item_ff.word_index));
            x_waddr  = raddr;
            z_waddr  = raddr;
            x_wdata  = item_ff.word_data[stge_pkg::WORD_BITS-1:0];
            z_wdata  = item_ff.word_data[stge_pkg::WORD_BITS-1:0];
            ph_wdata = item_ff.word_data[stge_pkg::WORD_BITS-1:0];
            state_in = S_DONE;
            if (32'(item_ff.word_index) < stge_pkg::WORDS_PER_COLUMN) begin
               if (item_ff.word_kind == stge_pkg::KIND_PHASE) begin
                  if (item_ff.mode == stge_pkg::MODE_WRITE) begin
                     ph_we = 1'b1;
                  end else begin
                     rd_in = 64'(phase_ff[stge_pkg::WIDX_W'(item_ff.word_index)]);
                  end
               end else if (32'(item_ff.target_qubit) < stge_pkg::QUBITS &&
                            (item_ff.word_kind == stge_pkg::KIND_X ||
                             item_ff.word_kind == stge_pkg::KIND_Z)) begin
                  if (item_ff.mode == stge_pkg::MODE_WRITE) begin
                     x_we = item_ff.word_kind == stge_pkg::KIND_X;
                     z_we = item_ff.word_kind == stge_pkg::KIND_Z;
                  end else begin
                     state_in = S_RD;
                  end
               end
            end
         end
         S_RD: begin
            rd_in    = 64'((item_ff.word_kind == stge_pkg::KIND_X) ? xe : ze);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         aw_ff        <= 2'd2;
         xval_ff      <= '0;
         zval_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < stge_pkg::WORDS_PER_COLUMN; i++) begin
            phase_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            aw_ff <= csr_data;
         end
         if (x_we) begin
            xval_ff[x_waddr] <= 1'b1;
         end
         if (z_we) begin
            zval_ff[z_waddr] <= 1'b1;
         end
         if (ph_we) begin
            phase_ff[(state_ff == S_WORD) ? stge_pkg::WIDX_W'(item_ff.word_index)
                                          : ph_idx] <= ph_wdata;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      desc_ff  <= desc_in;
      two_ff   <= two_in;
      cz_ff    <= cz_in;
      w_ff     <= w_in;
      limit_ff <= limit_in;
      rd_ff    <= rd_in;
      xv_ff    <= xval_ff[raddr];
      zv_ff    <= zval_ff[raddr];
      if (state_ff == S_RB) begin
         xa_ff <= xe;
         za_ff <= ze;
      end
      if (state_ff == S_WR) begin
         xb_ff <= xe;
      end
      if (load_rsp) begin
         rsp_ff.read_data <= rd_ff;
         rsp_ff.done_res  <= 1'b1;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   `STGE_ASSERT_IMPL(a_no_write_idle, state_ff == S_IDLE, !x_we && !z_we && !ph_we)
   `STGE_ASSERT_NEXT(a_leave_idle, req_valid && !req_stall, state_ff != S_IDLE)
   `STGE_ASSERT_IMPL(a_word_in_range,
      state_ff == S_RA || state_ff == S_RB || state_ff == S_WR || state_ff == S_WR2,
      w_ff < limit_ff)
   `STGE_ASSERT_IMPL(a_rsp_from_done, rsp_valid_ff && !$past(rsp_valid_ff),
      $past(state_ff) == S_DONE)

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the stabilizer tableau gate engine core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NQ = 64;
   localparam int NW = 2;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 200;
   localparam int MODE_SPARE_LO = 28;
   localparam int MODE_SPARE_HI = 31;
   localparam int KIND_SPARE = 3;

   typedef enum logic [4:0] {
      G_H = 5'd0, G_S, G_Z, G_R, G_I, G_X, G_Y, G_HX, G_SX, G_RX, G_HZ, G_HY, G_SH,
      G_RH, G_HS, G_HR, G_HSX, G_HRX, G_SHY, G_RHY, G_HSH, G_HRH, G_RHS, G_SHR,
      G_CNOT, G_CZ, G_WRITE, G_READ
   } gate_code_type;

   typedef enum logic [2:0] {
      P_NONE, P_XZ, P_X, P_XNZ, P_Z, P_XOR, P_NXZ, P_OR
   } phase_fn_type;

   typedef enum logic [1:0] {
      M_NONE, M_ZX, M_XZ
   } mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   stge_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   stge_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_data = 2'd2;

   stabilizer_tableau_gate_engine_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Tableau shadow kept by the predictor.
   logic [63:0] x_col [NQ][NW];
   logic [63:0] z_col [NQ][NW];
   logic [63:0] phase_word [NW];
   logic [1:0] word_count;

   stge_pkg::req_type pending_items[$];
   stge_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   bit calm = 1'b0;
   bit hold_rsp = 1'b0;
   int hold_count = 0;

   function automatic logic [63:0] phase_bits(phase_fn_type f, logic [63:0] x,
                                              logic [63:0] z);
      case (f)
         P_XZ: return x & z;
         P_X: return x;
         P_XNZ: return x & ~z;
         P_Z: return z;
         P_XOR: return x ^ z;
         P_NXZ: return ~x & z;
         P_OR: return x | z;
         default: return '0;
      endcase
   endfunction

   function automatic void apply_single(logic [4:0] m, int q);
      phase_fn_type pf;
      mix_type mx;
      bit ex;
      logic [63:0] x, z;
      case (gate_code_type'(m))
         G_H: begin pf = P_XZ; mx = M_NONE; ex = 1; end
         G_S: begin pf = P_XZ; mx = M_ZX; ex = 0; end
         G_Z: begin pf = P_X; mx = M_NONE; ex = 0; end
         G_R: begin pf = P_XNZ; mx = M_ZX; ex = 0; end
         G_I: begin pf = P_NONE; mx = M_NONE; ex = 0; end
         G_X: begin pf = P_Z; mx = M_NONE; ex = 0; end
         G_Y: begin pf = P_XOR; mx = M_NONE; ex = 0; end
         G_HX: begin pf = P_NXZ; mx = M_NONE; ex = 1; end
         G_SX: begin pf = P_NXZ; mx = M_ZX; ex = 0; end
         G_RX: begin pf = P_OR; mx = M_ZX; ex = 0; end
         G_HZ: begin pf = P_XNZ; mx = M_NONE; ex = 1; end
         G_HY: begin pf = P_XOR; mx = M_NONE; ex = 1; end
         G_SH: begin pf = P_NONE; mx = M_XZ; ex = 1; end
         G_RH: begin pf = P_Z; mx = M_XZ; ex = 1; end
         G_HS: begin pf = P_NONE; mx = M_XZ; ex = 1; end
         G_HR: begin pf = P_NONE; mx = M_ZX; ex = 1; end
         G_HSX: begin pf = P_XOR; mx = M_ZX; ex = 1; end
         G_HRX: begin pf = P_Z; mx = M_ZX; ex = 1; end
         G_SHY: begin pf = P_XOR; mx = M_XZ; ex = 1; end
         G_RHY: begin pf = P_X; mx = M_XZ; ex = 1; end
         G_HSH: begin pf = P_NXZ; mx = M_XZ; ex = 0; end
         G_HRH: begin pf = P_XZ; mx = M_XZ; ex = 0; end
         G_RHS: begin pf = P_OR; mx = M_XZ; ex = 0; end
         default: begin pf = P_XNZ; mx = M_XZ; ex = 0; end
      endcase
      for (int w = 0; w < NW; w++) begin
         if (w < word_count) begin
            x = x_col[q][w];
            z = z_col[q][w];
            phase_word[w] ^= phase_bits(pf, x, z);
            if (mx == M_ZX) z_col[q][w] = z ^ x;
            else if (mx == M_XZ) x_col[q][w] = x ^ z;
         end
      end
      if (ex) begin
         for (int w = 0; w < NW; w++) begin
            x = x_col[q][w];
            x_col[q][w] = z_col[q][w];
            z_col[q][w] = x;
         end
      end
   endfunction

   function automatic stge_pkg::rsp_type predict_tableau(stge_pkg::req_type r);
      stge_pkg::rsp_type o;
      int t, c;
      logic [63:0] xc, zc, xt, zt;
      o.read_data = '0;
      o.done_res = 1'b1;
      t = r.target_qubit;
      c = r.control_qubit;
      if (r.mode < G_CNOT) begin
         apply_single(r.mode, t);
      end else if (r.mode == G_CNOT || r.mode == G_CZ) begin
         if (t != c) begin
            for (int w = 0; w < NW; w++) begin
               if (w < word_count) begin
                  xc = x_col[c][w]; zc = z_col[c][w];
                  xt = x_col[t][w]; zt = z_col[t][w];
                  if (r.mode == G_CZ) begin
                     phase_word[w] ^= xc & xt & (zc ^ zt);
                     z_col[t][w] = zt ^ xc;
                     z_col[c][w] = zc ^ xt;
                  end else begin
                     phase_word[w] ^= xc & zt & ~(xt ^ zc);
                     x_col[t][w] = xt ^ xc;
                     z_col[c][w] = zc ^ zt;
                  end
               end
            end
         end
      end else if (r.mode == G_WRITE) begin
         case (r.word_kind)
            stge_pkg::KIND_X: x_col[t][r.word_index] = r.word_data;
            stge_pkg::KIND_Z: z_col[t][r.word_index] = r.word_data;
            stge_pkg::KIND_PHASE: phase_word[r.word_index] = r.word_data;
            default: ;
         endcase
      end else if (r.mode == G_READ) begin
         case (r.word_kind)
            stge_pkg::KIND_X: o.read_data = x_col[t][r.word_index];
            stge_pkg::KIND_Z: o.read_data = z_col[t][r.word_index];
            stge_pkg::KIND_PHASE: o.read_data = phase_word[r.word_index];
            default: ;
         endcase
      end
      return o;
   endfunction

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic stge_pkg::req_type make_item(int m, int t, int c, int k, int i,
                                                   logic [63:0] d);
      stge_pkg::req_type r;
      r.mode = 5'(m);
      r.target_qubit = 6'(t);
      r.control_qubit = 6'(c);
      r.word_kind = 2'(k);
      r.word_index = 1'(i);
      r.word_data = d;
      return r;
   endfunction

   function automatic stge_pkg::req_type rand_item();
      int t;
      t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
      case ($urandom_range(0, 9))
         0, 1: return make_item(G_WRITE, t, $urandom, $urandom, $urandom, rand_word());
         2, 3: return make_item(G_READ, t, $urandom, $urandom, $urandom, rand_word());
         4: return make_item($urandom_range(G_CNOT, G_CZ), t,
                             ($urandom_range(0, 7) == 0) ? t : $urandom_range(0, 3),
                             $urandom, $urandom, rand_word());
         5: return make_item($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI), t, $urandom,
                             $urandom, $urandom, rand_word());
         default: return make_item($urandom_range(G_H, G_SHR), t, $urandom, $urandom,
                                   $urandom, rand_word());
      endcase
   endfunction

   // Driver: offers pending items, idling now and then unless in a calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
            req_valid <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Expectations are formed as items are accepted.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_rsps.push_back(predict_tableau(req_data));
   end

   // Receiver stall: random, or held for a counted stretch while a hold is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_count <= 0;
      end else if (hold_rsp && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= !calm && $urandom_range(0, 99) < 7;
         if (!hold_rsp) hold_count <= 0;
      end
   end

   // Monitor and checker.
   always @(posedge clock) begin
      stge_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.read_data !== e.read_data) begin
               $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                        rsp_data.read_data);
               errors++;
            end
            if (rsp_data.done_res !== e.done_res) begin
               $display("%0t: done_res expected %b actual %b", $time, e.done_res,
                        rsp_data.done_res);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted item on either side and no hold requested.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_rsp)
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_words(logic [1:0] v);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      word_count = v;
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
      drain();
   endtask

   initial begin
      for (int q = 0; q < NQ; q++)
         for (int w = 0; w < NW; w++) begin
            x_col[q][w] = '0;
            z_col[q][w] = '0;
         end
      phase_word[0] = '0;
      phase_word[1] = '0;
      word_count = 2;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every gate, degenerate two-qubit gates, bad kinds.
      pending_items.push_back(make_item(G_WRITE, 0, 0, stge_pkg::KIND_X, 0, '1));
      pending_items.push_back(make_item(G_WRITE, 63, 0, stge_pkg::KIND_Z, 1,
                                        64'hA5A5_5A5A_F00F_0FF0));
      pending_items.push_back(make_item(G_WRITE, 1, 0, stge_pkg::KIND_PHASE, 1, '1));
      pending_items.push_back(make_item(G_WRITE, 5, 0, KIND_SPARE, 0, '1));
      pending_items.push_back(make_item(G_READ, 5, 0, KIND_SPARE, 1, '0));
      pending_items.push_back(make_item(G_WRITE, 1, 0, stge_pkg::KIND_X, 0,
                                        64'h0123_4567_89AB_CDEF));
      pending_items.push_back(make_item(G_WRITE, 1, 0, stge_pkg::KIND_Z, 0,
                                        64'hFEDC_BA98_7654_3210));
      for (int m = 0; m < int'(stge_pkg::GATE_COUNT); m++)
         pending_items.push_back(make_item(m, 1, 63, 0, 0, '0));
      drain();
      pending_items.push_back(make_item(G_CNOT, 1, 0, 0, 0, '0));
      pending_items.push_back(make_item(G_CZ, 0, 63, 0, 0, '0));
      pending_items.push_back(make_item(G_CNOT, 7, 7, 0, 0, '0));
      pending_items.push_back(make_item(G_CZ, 63, 63, 0, 0, '0));
      pending_items.push_back(make_item(MODE_SPARE_HI, 1, 1, KIND_SPARE, 1, '1));
      pending_items.push_back(make_item(MODE_SPARE_LO, 0, 0, 0, 0, '0));
      for (int k = 0; k < 3; k++)
         for (int w = 0; w < 2; w++) begin
            pending_items.push_back(make_item(G_READ, 1, 0, k, w, '0));
            pending_items.push_back(make_item(G_READ, 63, 0, k, w, '0));
         end
      drain();

      // Random phases across word counts, including zero and one above the words per column.
      write_words(2'd1);
      random_phase(300);
      write_words(2'd0);
      random_phase(200);
      write_words(2'd3);
      random_phase(250);

      // Back-pressure: hold the receiver off while the sender keeps offering.
      write_words(2'd2);
      calm = 1'b1;
      hold_rsp = 1'b1;
      for (int i = 0; i < 60; i++) pending_items.push_back(rand_item());
      wait (hold_count == HOLD_CYCLES);
      hold_rsp = 1'b0;
      random_phase(400);
      calm = 1'b0;
      random_phase(490);
      drain();

      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
